// ===== src/cnms_pkg.sv =====
// ---------------------------------------------------------------------------
// cnms_pkg: shared constants and types for the circle NMS filter
// Widths of the stream payloads, the center memory and the distance datapath.
// ---------------------------------------------------------------------------
package cnms_pkg;

  localparam int MAX_KEPT   = 256;
  localparam int COORD_BITS = 18;
  localparam int RADIUS_W   = 17;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int COUNT_W    = 9;
  localparam int COUNT_MAX  = (1 << COUNT_W) - 1;

  localparam int FILL_W = $clog2(MAX_KEPT + 1);
  localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int ENTRY_W = 2 * COORD_BITS;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = COUNT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Bit positions of the result fields inside the output tdata.
  localparam int OUT_KEEP_BIT = 0;
  localparam int OUT_TOT_LSB  = 1;
  localparam int OUT_TOT_MSB  = COUNT_W;
  localparam int OUT_OVF_BIT  = COUNT_W + 1;

  typedef struct packed {
    logic busy;
    logic hit;
  } dist_status_t;

endpackage

// ===== src/circle_nms_filter.sv =====
// ---------------------------------------------------------------------------
// circle_nms_filter: greedy circle non-maximum suppression
// Compares each box center with the kept centers of its set and reports it.
// ---------------------------------------------------------------------------
// Scan: the fill centers stored for the set (0 to MAX_KEPT = 256) are read in turn
// by the single read port, one center per cycle until a suppressing center comes
// back; each passes the absolute-difference, square and compare registers. An
// empty table needs no reads. Items are handled one at a time: the next is
// accepted once the result is shown; the result waits in WB while the output stalls.
// Reset: rst clears the control state, the count and the radius at once; the
// center memory is not cleared, since only entries below the fill are read.
module circle_nms_filter (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: radius, 17 bits unsigned.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cnms_pkg::RADIUS_W-1:0]     cfg_data,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: center_x[17:0], center_y[35:18], zero fill.
  input  logic [cnms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: first_box.
  input  logic                              s_axis_tuser,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: keep, kept_total[9:1], table_overflow[10], zero fill.
  output logic [cnms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import cnms_pkg::*;

  // IDLE waits for an item, SCAN streams the stored centers through the
  // distance pipeline, WB stores a kept center and hands the result over.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB
  } state_t;

  state_t                  state;
  logic [FILL_W-1:0]       fill;
  logic [COUNT_W-1:0]      kept_count;
  logic [COUNT_W-1:0]      count_inc;
  logic [R2_W-1:0]         radius_sq;
  logic [R2_W-1:0]         cfg_sq;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic [FILL_W-1:0]       issue_idx;
  logic                    rd_pending;
  logic                    keep_box;
  logic                    out_keep;
  logic [COUNT_W-1:0]      out_total;
  logic                    out_ovf;

  logic                    out_free;
  logic                    rd_en;
  logic                    scan_clear;
  logic                    wr_en;
  logic                    flush;
  logic [ENTRY_W-1:0]      rd_data;
  dist_status_t            stat;

  // The register takes writes at any time; the squared radius is kept so the
  // compare path holds no multiplier.
  assign cfg_ready = 1'b1;
  assign cfg_sq    = cfg_data * cfg_data;

  assign s_axis_tready = (state == S_IDLE);

  // The result register can take a new item when it is empty or being read.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Stop issuing reads once a suppressing center has come back.
  assign rd_en = (state == S_SCAN) && (issue_idx < fill) && !stat.hit;

  // Every stored center was compared and none was too close.
  assign scan_clear = (state == S_SCAN) && (issue_idx == fill) && !rd_pending &&
                      !stat.busy && !stat.hit;

  // A kept box is appended while there is room; the memory never sees a read
  // of this entry in the same item, so no forwarding is needed.
  assign wr_en = (state == S_WB) && out_free && keep_box && (fill < FILL_W'(MAX_KEPT));

  // In-flight compares are dropped whenever no scan is running.
  assign flush = (state != S_SCAN);

  assign count_inc = (kept_count == COUNT_W'(COUNT_MAX)) ? kept_count : kept_count + 1'b1;

  cnms_ram #(
    .DEPTH (MAX_KEPT),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data ({box_y, box_x}),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  cnms_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .flush     (flush),
    .in_valid  (rd_pending),
    .ref_x     (box_x),
    .ref_y     (box_y),
    .entry     (rd_data),
    .radius_sq (radius_sq),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      kept_count    <= '0;
      radius_sq     <= '0;
      rd_pending    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        radius_sq <= cfg_sq;
      end
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      rd_pending <= rd_en;

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            box_x     <= s_axis_tdata[COORD_BITS-1:0];
            box_y     <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
            issue_idx <= '0;
            // A new set empties the table before this box is judged.
            if (s_axis_tuser) begin
              fill       <= '0;
              kept_count <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (stat.hit) begin
            keep_box <= 1'b0;
            state    <= S_WB;
          end else if (scan_clear) begin
            keep_box <= 1'b1;
            state    <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_keep      <= keep_box;
            out_ovf       <= keep_box && (fill == FILL_W'(MAX_KEPT));
            out_total     <= keep_box ? count_inc : kept_count;
            if (keep_box) begin
              kept_count <= count_inc;
              if (fill < FILL_W'(MAX_KEPT)) begin
                fill <= fill + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_ovf, out_total, out_keep};

endmodule

// ===== src/cnms_ram.sv =====
// ---------------------------------------------------------------------------
// cnms_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module cnms_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 36
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cnms_dist.sv =====
// ---------------------------------------------------------------------------
// cnms_dist: pipelined squared-distance compare
// Absolute differences, exact squares, then sum against the squared radius.
// ---------------------------------------------------------------------------
module cnms_dist (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  flush,
  input  logic                                  in_valid,
  input  logic signed [cnms_pkg::COORD_BITS-1:0] ref_x,
  input  logic signed [cnms_pkg::COORD_BITS-1:0] ref_y,
  input  logic [cnms_pkg::ENTRY_W-1:0]          entry,
  input  logic [cnms_pkg::R2_W-1:0]             radius_sq,
  output cnms_pkg::dist_status_t                stat
);
  import cnms_pkg::*;

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]   dx_abs;
  logic [COORD_BITS:0]   dy_abs;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic                  a_valid;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_y;
  logic                  b_valid;
  logic [CMP_W-1:0]      dist_sq;
  logic                  hit;

  // Entry holds y in the upper half and x in the lower half.
  assign dx = {ref_x[COORD_BITS-1], ref_x} - {entry[COORD_BITS-1], entry[COORD_BITS-1:0]};
  assign dy = {ref_y[COORD_BITS-1], ref_y} -
              {entry[ENTRY_W-1], entry[ENTRY_W-1:COORD_BITS]};
  assign dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

  assign dist_sq = CMP_W'(sq_x) + CMP_W'(sq_y);

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      hit     <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      hit     <= b_valid && (dist_sq < CMP_W'(radius_sq));
    end
  end

  always_ff @(posedge clk) begin
    ax   <= dx_abs[COORD_BITS-1:0];
    ay   <= dy_abs[COORD_BITS-1:0];
    sq_x <= ax * ax;
    sq_y <= ay * ay;
  end

  assign stat.busy = a_valid || b_valid;
  assign stat.hit  = hit;

endmodule

// ===== src/cnms_checker.sv =====
// ---------------------------------------------------------------------------
// cnms_checker: port-level checks for the circle NMS filter
// Watches the stream ports and the result fields over time.
// ---------------------------------------------------------------------------
module cnms_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [cnms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import cnms_pkg::*;

  // Items are handled one at a time: the input closes right after an item.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input stayed open after an item was taken");

  // An overflow is only ever reported for a kept box.
  a_ovf_kept: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[OUT_OVF_BIT]) |-> m_axis_tdata[OUT_KEEP_BIT])
    else $error("overflow reported for a suppressed box");

  // A kept box is always counted.
  a_kept_counted: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[OUT_KEEP_BIT]) |->
      (m_axis_tdata[OUT_TOT_MSB:OUT_TOT_LSB] != '0))
    else $error("kept box with a zero kept count");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind circle_nms_filter cnms_checker u_cnms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
